// ----- rtl/core/drum_pad_velocity_detector_assert.svh -----
`ifndef DRUM_PAD_VELOCITY_DETECTOR_ASSERT_SVH
`define DRUM_PAD_VELOCITY_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DPVD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define DPVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/core/dpvd_pkg.sv -----
package dpvd_pkg;

   localparam int SAMPLE_BITS      = 12;
   localparam int CURVE_INDEX_BITS = 8;
   localparam int CURVE_ENTRIES    = 1 << CURVE_INDEX_BITS;
   localparam int CNT_BITS         = $clog2(CURVE_INDEX_BITS + 1);
   localparam int WINDOW_BITS      = 8;
   localparam int VEL_BITS         = 7;
   localparam int CSR_DATA_BITS    = (SAMPLE_BITS > WINDOW_BITS) ? SAMPLE_BITS : WINDOW_BITS;
   localparam int CSR_INDEX_BITS   = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIG_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_SCALE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_SELECT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_MS    = 2'd3;

   // curve codes (the unused code maps linearly)
   localparam logic [1:0] CURVE_STRAIGHT = 2'd0;
   localparam logic [1:0] CURVE_COMPRESS = 2'd1;
   localparam logic [1:0] CURVE_POW      = 2'd2;

   localparam logic [SAMPLE_BITS-1:0] TRIG_LEVEL_RST   = SAMPLE_BITS'(400);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RST   = SAMPLE_BITS'(4095);
   localparam logic [1:0]             CURVE_SELECT_RST = CURVE_STRAIGHT;
   localparam logic [WINDOW_BITS-1:0] WINDOW_MS_RST    = WINDOW_BITS'(5);

   localparam logic [WINDOW_BITS-1:0] ELAPSED_MAX = '1;
   localparam logic [VEL_BITS-1:0]    VEL_MAX     = VEL_BITS'(127);
   localparam logic [VEL_BITS-1:0]    VEL_MIN     = VEL_BITS'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic new_hit;
      logic close;
   } trk_status_type;

   typedef struct packed {
      logic busy;
   } div_status_type;

   typedef logic [VEL_BITS-1:0] vel_table_type [CURVE_ENTRIES];

   // Velocity for one curve index, arithmetic mostly in Q16.
   function automatic logic [VEL_BITS-1:0] curve_point(input logic [1:0] sel,
                                                       input int unsigned idx);
      longint unsigned x;
      longint unsigned y;
      longint unsigned t;
      longint unsigned z;
      longint unsigned m;
      longint unsigned frac;
      longint unsigned k;
      longint unsigned v;
      longint unsigned res;
      longint unsigned bitv;
      int b;
      x = longint'(idx) << (16 - CURVE_INDEX_BITS);
      if (sel == CURVE_COMPRESS) begin
         z = 64'd65536 + 64'd9 * x;
         k = 0;
         for (b = 0; b < 4; b++) begin
            if ((z >> k) >= 64'd131072) k = k + 1;
         end
         m = z >> k;
         frac = 0;
         for (b = 15; b >= 0; b--) begin
            m = (m * m) >> 16;
            if (m >= 64'd131072) begin
               m = m >> 1;
               frac = frac | (64'd1 << b);
            end
         end
         y = (((k << 16) | frac) * 64'd2485766) >> 16;
      end else if (sel == CURVE_POW) begin
         // bit-by-bit integer square root of x in Q32
         v = x << 16;
         res = 0;
         for (b = 31; b >= 0; b--) begin
            bitv = 64'd1 << (2 * b);
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
         end
         y = 64'd126 * ((x * res) >> 16);
      end else begin
         y = 64'd126 * x;
      end
      t = y + 64'd65536;
      if (t >= 64'd8290304) return VEL_MAX;
      return VEL_BITS'(t >> 16);
   endfunction

   function automatic vel_table_type build_table(input logic [1:0] sel);
      vel_table_type tbl;
      for (int i = 0; i < CURVE_ENTRIES; i++) begin
         tbl[i] = curve_point(sel, i);
      end
      return tbl;
   endfunction

endpackage

// ----- rtl/core/dpvd_track.sv -----
module dpvd_track
   import dpvd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   ms_tick,
   input  logic [SAMPLE_BITS-1:0] trig_level,
   input  logic [WINDOW_BITS-1:0] window_ms,
   output trk_status_type         status,
   output logic [SAMPLE_BITS-1:0] peak
);

   logic                   measuring_ff;
   logic                   prev_hit_ff;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [WINDOW_BITS-1:0] elapsed_ff;

   logic                   hit;
   logic                   opened;
   logic                   meas_now;
   logic [SAMPLE_BITS-1:0] peak_base;
   logic [SAMPLE_BITS-1:0] peak_in;
   logic [WINDOW_BITS-1:0] elapsed_in;

   always_comb begin
      hit      = sample > trig_level;
      opened   = hit & ~measuring_ff;
      meas_now = measuring_ff | hit;

      peak_base = opened ? '0 : peak_ff;
      if (meas_now && sample > peak_base) begin
         peak_in = sample;
      end else begin
         peak_in = peak_base;
      end

      // timer restarts when the window opens; no tick counted on that sample
      if (opened) begin
         elapsed_in = '0;
      end else if (measuring_ff && ms_tick && elapsed_ff != ELAPSED_MAX) begin
         elapsed_in = elapsed_ff + WINDOW_BITS'(1);
      end else begin
         elapsed_in = elapsed_ff;
      end

      status.new_hit = hit & ~prev_hit_ff;
      status.close   = meas_now & ~hit &
                       ((elapsed_in > window_ms) | (elapsed_in == ELAPSED_MAX));
      peak = peak_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff <= 1'b0;
         prev_hit_ff  <= 1'b0;
         peak_ff      <= '0;
         elapsed_ff   <= '0;
      end else if (accept) begin
         measuring_ff <= meas_now & ~status.close;
         prev_hit_ff  <= hit;
         peak_ff      <= status.close ? '0 : peak_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

// ----- rtl/core/dpvd_div.sv -----
module dpvd_div
   import dpvd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SAMPLE_BITS-1:0] peak,
   input  logic [SAMPLE_BITS-1:0] trig_level,
   input  logic [SAMPLE_BITS-1:0] full_scale,
   input  logic [1:0]             curve_select,
   output div_status_type         status,
   output logic [VEL_BITS-1:0]    velocity
);

   localparam vel_table_type LIN_TABLE = build_table(CURVE_STRAIGHT);
   localparam vel_table_type LOG_TABLE = build_table(CURVE_COMPRESS);
   localparam vel_table_type POW_TABLE = build_table(CURVE_POW);

   logic [CNT_BITS-1:0]         cnt_ff;
   logic [SAMPLE_BITS-1:0]      rem_ff;
   logic [SAMPLE_BITS-1:0]      den_ff;
   logic [CURVE_INDEX_BITS-1:0] quo_ff;
   logic                        sat_ff;
   logic                        low_ff;
   logic [1:0]                  curve_ff;

   logic [SAMPLE_BITS:0]        rem_dbl;
   logic                        fits;
   logic [SAMPLE_BITS:0]        rem_sub;
   logic [VEL_BITS-1:0]         curve_vel;

   // remainder stays below the divisor, so one compare-subtract per bit
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      fits    = rem_dbl >= {1'b0, den_ff};
      rem_sub = rem_dbl - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_BITS'(CURVE_INDEX_BITS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= peak - trig_level;
         den_ff   <= full_scale - trig_level;
         quo_ff   <= '0;
         sat_ff   <= peak >= full_scale;
         low_ff   <= peak <= trig_level;
         curve_ff <= curve_select;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? rem_sub[SAMPLE_BITS-1:0] : rem_dbl[SAMPLE_BITS-1:0];
         quo_ff <= {quo_ff[CURVE_INDEX_BITS-2:0], fits};
      end
   end

   always_comb begin
      unique case (curve_ff)
         CURVE_COMPRESS: curve_vel = LOG_TABLE[quo_ff];
         CURVE_POW:      curve_vel = POW_TABLE[quo_ff];
         default:        curve_vel = LIN_TABLE[quo_ff];
      endcase
      priority if (sat_ff) begin
         velocity = VEL_MAX;
      end else if (low_ff) begin
         velocity = VEL_MIN;
      end else begin
         velocity = curve_vel;
      end
      status.busy = cnt_ff != '0;
   end

endmodule

// ----- rtl/core/drum_pad_velocity_detector.sv -----
// Piezo drum pad trigger. Each transfer on req_ carries one converter sample and a
// millisecond tick and yields exactly one rsp_ transfer: new_hit on the rising edge
// of a hit (sample above the trigger level), and measure_done with a velocity of
// 1..127 when a measuring window closes on a non-hit sample after more than
// window_ms ticks or when the tick counter saturates. A sample that closes no
// window loads its answer straight into the output register. For a closing sample
// the bit-serial divider that normalizes the peak between trigger level and full
// scale produces one curve index bit per cycle, S_DIV sees the divider finish and
// S_EMIT reads the curve table into the output register. A stalled rsp_ holds off
// req_. Registers must be written through csr_ (index 0 trigger level, 1 full
// scale, 2 curve select, 3 window_ms) only while no item is in flight; not enforced.
module drum_pad_velocity_detector
   import dpvd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      req_ms_tick,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_new_hit,
   output logic                      rsp_measure_done,
   output logic [VEL_BITS-1:0]       rsp_velocity,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

`include "drum_pad_velocity_detector_assert.svh"

   state_type state_ff;
   state_type state_in;

   logic [SAMPLE_BITS-1:0] trig_level_ff;
   logic [SAMPLE_BITS-1:0] full_scale_ff;
   logic [1:0]             curve_select_ff;
   logic [WINDOW_BITS-1:0] window_ms_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_new_hit_ff;
   logic                   rsp_done_ff;
   logic [VEL_BITS-1:0]    rsp_velocity_ff;
   logic                   pend_new_hit_ff;

   trk_status_type         trk_stat;
   div_status_type         div_stat;
   logic [SAMPLE_BITS-1:0] trk_peak;
   logic [VEL_BITS-1:0]    div_velocity;

   logic req_fire;
   logic rsp_free;
   logic div_start;
   logic load_item;
   logic load_done;

   assign req_fire = req_valid & req_ready;
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   dpvd_track u_track (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .sample     (req_sample),
      .ms_tick    (req_ms_tick),
      .trig_level (trig_level_ff),
      .window_ms  (window_ms_ff),
      .status     (trk_stat),
      .peak       (trk_peak)
   );

   dpvd_div u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .peak         (trk_peak),
      .trig_level   (trig_level_ff),
      .full_scale   (full_scale_ff),
      .curve_select (curve_select_ff),
      .status       (div_stat),
      .velocity     (div_velocity)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (div_start) state_in = S_DIV;
         S_DIV:  if (!div_stat.busy) state_in = S_EMIT;
         S_EMIT: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE) & rsp_free;
      div_start = req_fire & trk_stat.close;
      load_item = req_fire & ~trk_stat.close;
      load_done = (state_ff == S_EMIT) & rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_level_ff   <= TRIG_LEVEL_RST;
         full_scale_ff   <= FULL_SCALE_RST;
         curve_select_ff <= CURVE_SELECT_RST;
         window_ms_ff    <= WINDOW_MS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TRIG_LEVEL:   trig_level_ff   <= csr_data[SAMPLE_BITS-1:0];
            CSR_FULL_SCALE:   full_scale_ff   <= csr_data[SAMPLE_BITS-1:0];
            CSR_CURVE_SELECT: curve_select_ff <= csr_data[1:0];
            CSR_WINDOW_MS:    window_ms_ff    <= csr_data[WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_item || load_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         pend_new_hit_ff <= trk_stat.new_hit;
      end
      if (load_item) begin
         rsp_new_hit_ff  <= trk_stat.new_hit;
         rsp_done_ff     <= 1'b0;
         rsp_velocity_ff <= '0;
      end else if (load_done) begin
         rsp_new_hit_ff  <= pend_new_hit_ff;
         rsp_done_ff     <= 1'b1;
         rsp_velocity_ff <= div_velocity;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_hit      = rsp_new_hit_ff;
   assign rsp_measure_done = rsp_done_ff;
   assign rsp_velocity     = rsp_velocity_ff;

   `DPVD_ASSERT_SAME(a_done_has_velocity, clock, reset,
      rsp_valid_ff && rsp_done_ff, rsp_velocity_ff != '0)
   `DPVD_ASSERT_SAME(a_idle_no_velocity, clock, reset,
      rsp_valid_ff && !rsp_done_ff, rsp_velocity_ff == '0)
   `DPVD_ASSERT_NEXT(a_close_starts_div, clock, reset,
      div_start, state_ff == S_DIV && div_stat.busy)
   `DPVD_ASSERT_SAME(a_no_accept_busy, clock, reset,
      div_stat.busy, !req_ready)

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import dpvd_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          NUM_SETTINGS = 10;
   localparam int          SETTLE_CYC   = CURVE_INDEX_BITS + 4;
   localparam logic [1:0]  CURVE_SPARE  = 2'd3;
   localparam longint unsigned Q16_ONE       = 64'd65536;
   localparam longint unsigned LOG_GAIN_Q16  = 64'd2485766;  // 126 * log10(2)
   localparam longint unsigned VEL_TOP_Q16   = 64'd8290304;  // 126.5

   typedef struct packed {
      logic                new_hit;
      logic                done;
      logic [VEL_BITS-1:0] velocity;
   } pad_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [11:0]               value;   // sample, or register data
      logic                      tick;
      logic                      pinned;  // expected result typed in below
      pad_result_type            want;
   } stim_row_type;

   typedef struct {
      int unsigned    item;
      pad_result_type want;
   } pinned_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample = '0;
   logic                      req_ms_tick = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_new_hit;
   logic                      rsp_measure_done;
   logic [VEL_BITS-1:0]       rsp_velocity;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   drum_pad_velocity_detector u_dut (.*);

   always #5 clock = ~clock;

   // shadow registers and pad state, updated on accepted transfers
   logic [11:0] thr_reg, upper_reg;
   logic [1:0]  curve_reg;
   logic [7:0]  window_reg;
   logic        pad_measuring, pad_prev_hit;
   logic [11:0] pad_peak;
   logic [7:0]  pad_elapsed;

   pad_result_type pending_results[$];
   pinned_type     pinned_q[$];

   int n_sent = 0, n_accepted = 0, n_results = 0, n_closed = 0;
   int n_writes = 0, n_errors = 0, cycle_count = 0;
   bit send_idle = 1'b1, recv_idle = 1'b1;

   stim_row_type directed_rows [32] = '{
      '{ROW_SAMPLE, '0, 12'd0,    1'b0, 1'b1, '{1'b0, 1'b0, 7'd0}},
      // level equal to the threshold is no hit
      '{ROW_SAMPLE, '0, 12'd400,  1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      // tick on the opening sample is not counted
      '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b1, 7'd127}},
      '{ROW_WRITE, CSR_CURVE_SELECT, {10'h3FF, CURVE_COMPRESS}, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_WINDOW_MS,    {4'hF, 8'd0},              1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd3000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd50,   1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_CURVE_SELECT, {10'h000, CURVE_POW},   1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd2048, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_CURVE_SELECT, {10'h000, CURVE_SPARE}, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd2048, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b0, '0},
      // threshold raised while the window is open: peak falls below it
      '{ROW_SAMPLE, '0, 12'd1000, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{ROW_WRITE, CSR_TRIG_LEVEL, 12'd2000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd1500, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd1}},
      // full scale below threshold
      '{ROW_WRITE, CSR_FULL_SCALE, 12'd0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd4000, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b1, 7'd127}},
      '{ROW_WRITE, CSR_TRIG_LEVEL, 12'hFFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{ROW_WRITE, CSR_TRIG_LEVEL, 12'd0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_FULL_SCALE, 12'hFFF, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_CURVE_SELECT, {10'h300, CURVE_STRAIGHT}, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, 12'd1,    1'b0, 1'b1, '{1'b1, 1'b0, 7'd0}},
      '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{1'b0, 1'b1, 7'd1}}
   };

   function automatic logic [VEL_BITS-1:0] peak_to_velocity(input logic [11:0] peak);
      longint unsigned pk, th, up, idx, x, y, t, z, mant, frac, k, root, trial;
      pk = peak;
      th = thr_reg;
      up = upper_reg;
      if (pk >= up) return VEL_MAX;
      if (pk <= th) return VEL_MIN;
      idx = ((pk - th) << CURVE_INDEX_BITS) / (up - th);
      x = idx << (16 - CURVE_INDEX_BITS);
      case (curve_reg)
         CURVE_COMPRESS: begin
            z = Q16_ONE + 64'd9 * x;
            k = 0;
            while ((z >> k) >= 2 * Q16_ONE) k++;
            mant = z >> k;
            frac = 0;
            for (int b = 15; b >= 0; b--) begin
               mant = (mant * mant) >> 16;
               if (mant >= 2 * Q16_ONE) begin
                  mant = mant >> 1;
                  frac = frac | (64'd1 << b);
               end
            end
            y = (((k << 16) | frac) * LOG_GAIN_Q16) >> 16;
         end
         CURVE_POW: begin
            // floor(sqrt(x << 16)), one result bit at a time
            root = 0;
            for (int b = 15; b >= 0; b--) begin
               trial = root | (64'd1 << b);
               if (trial * trial <= (x << 16)) root = trial;
            end
            y = 64'd126 * ((x * root) >> 16);
         end
         default: y = 64'd126 * x;
      endcase
      t = y + Q16_ONE;
      if (t >= VEL_TOP_Q16) return VEL_MAX;
      return VEL_BITS'(t >> 16);
   endfunction

   task automatic advance_pad(input logic [11:0] smp, input logic tick,
                              output pad_result_type res);
      logic hit, opened;
      hit = smp > thr_reg;
      opened = 1'b0;
      res = '0;
      if (hit && !pad_measuring) begin
         pad_measuring = 1'b1;
         pad_peak = '0;
         pad_elapsed = '0;
         opened = 1'b1;
      end
      res.new_hit = hit && !pad_prev_hit;
      pad_prev_hit = hit;
      if (pad_measuring) begin
         if (!opened && tick && pad_elapsed != 8'd255) pad_elapsed++;
         if (smp > pad_peak) pad_peak = smp;
         if (!hit && (pad_elapsed > window_reg || pad_elapsed == 8'd255)) begin
            res.velocity = peak_to_velocity(pad_peak);
            res.done = 1'b1;
            pad_peak = '0;
            pad_measuring = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      pad_result_type got, want;
      pinned_type     pin;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[%0t] timeout: %0d samples accepted, %0d responses pending", $time,
                  n_accepted, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end else if (reset) begin
         pad_measuring = 1'b0;
         pad_prev_hit  = 1'b0;
         pad_peak      = '0;
         pad_elapsed   = '0;
         thr_reg    = TRIG_LEVEL_RST;
         upper_reg  = FULL_SCALE_RST;
         curve_reg  = CURVE_SELECT_RST;
         window_reg = WINDOW_MS_RST;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_new_hit, rsp_measure_done, rsp_velocity};
            n_results++;
            if (got.done) n_closed++;
            if (pending_results.size() == 0) begin
               n_errors++;
               $display("[%0t] unexpected response: new_hit %0d done %0d velocity %0d",
                        $time, got.new_hit, got.done, got.velocity);
            end else begin
               want = pending_results.pop_front();
               if (got.new_hit !== want.new_hit) begin
                  n_errors++;
                  $display("[%0t] new_hit mismatch: expected %0d, got %0d", $time,
                           want.new_hit, got.new_hit);
               end
               if (got.done !== want.done) begin
                  n_errors++;
                  $display("[%0t] measure_done mismatch: expected %0d, got %0d", $time,
                           want.done, got.done);
               end
               if (got.velocity !== want.velocity) begin
                  n_errors++;
                  $display("[%0t] velocity mismatch: expected %0d, got %0d", $time,
                           want.velocity, got.velocity);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIG_LEVEL:   thr_reg    = csr_data[11:0];
               CSR_FULL_SCALE:   upper_reg  = csr_data[11:0];
               CSR_CURVE_SELECT: curve_reg  = csr_data[1:0];
               CSR_WINDOW_MS:    window_reg = csr_data[7:0];
               default: ;
            endcase
            n_writes++;
         end
         if (req_valid && req_ready) begin
            advance_pad(req_sample, req_ms_tick, want);
            if (pinned_q.size() != 0 && pinned_q[0].item == n_accepted) begin
               pin = pinned_q.pop_front();
               want = pin.want;
            end
            pending_results.push_back(want);
            n_accepted++;
         end
      end
   end

   // result side: random stall ahead of each transfer while recv_idle is set
   initial begin : rsp_side
      int stall, target;
      @(negedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(6) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         target = n_results + 1;
         do @(negedge clock); while (n_results < target);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_sample(input logic [11:0] smp, input logic tick);
      int gap;
      gap = send_idle ? $urandom_range(6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= smp;
      req_ms_tick <= tick;
      n_sent++;
      do @(negedge clock); while (n_accepted < n_sent);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [11:0] data);
      int target;
      target = n_writes + 1;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (n_writes < target);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, wait for every response, then let the divider finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   function automatic logic [11:0] quiet_level();
      if ($urandom_range(3) == 0) return thr_reg;
      return 12'($urandom_range(int'(thr_reg)));
   endfunction

   function automatic logic [11:0] hit_level();
      if ($urandom_range(5) == 0) return 12'hFFF;
      return 12'($urandom_range(4095, int'(thr_reg) + 1));
   endfunction

   // quiet lead-in, a burst of hits with an occasional quiet dip, then quiet samples until the window closes
   task automatic play_stroke();
      int lead, burst, dip_at;
      lead = $urandom_range(2);
      repeat (lead) send_sample(quiet_level(), 1'($urandom_range(1)));
      burst = $urandom_range(4, 1);
      dip_at = ($urandom_range(7) == 0) ? $urandom_range(burst - 1) : 0;
      for (int i = 0; i < burst; i++) begin
         if (dip_at != 0 && i == dip_at) send_sample(quiet_level(), 1'($urandom_range(1)));
         send_sample(hit_level(), 1'($urandom_range(1)));
      end
      while (pad_measuring) send_sample(quiet_level(), 1'($urandom_range(3) != 0));
   endtask

   initial begin : stimulus
      logic [11:0] thr, upper;
      logic [1:0]  curve;
      logic [7:0]  window;
      int          quota, start;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            if (directed_rows[i].pinned)
               pinned_q.push_back('{n_sent, directed_rows[i].want});
            send_sample(directed_rows[i].value, directed_rows[i].tick);
         end
      end

      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         case (phase)
            0: begin
               thr = 12'd0; upper = 12'hFFF; curve = CURVE_COMPRESS; window = 8'd0;
            end
            1: begin  // nothing can be a hit
               thr = 12'hFFF; upper = 12'($urandom_range(4095)); curve = CURVE_POW;
               window = 8'd1;
            end
            2: begin
               thr = 12'($urandom_range(4000)); upper = 12'd0; curve = CURVE_STRAIGHT;
               window = 8'd2;
            end
            3: begin  // longest window, timer runs into saturation
               thr = 12'($urandom_range(2000, 100)); upper = 12'hFFF; curve = CURVE_POW;
               window = 8'd255;
            end
            default: begin
               thr = 12'($urandom_range(3000));
               upper = ($urandom_range(7) == 0) ? 12'($urandom_range(int'(thr)))
                                                : 12'($urandom_range(4095, int'(thr) + 1));
               curve = 2'($urandom_range(3));
               window = 8'($urandom_range(6));
            end
         endcase
         settle();
         send_idle = $urandom_range(3) != 0;
         recv_idle = $urandom_range(3) != 0;
         write_reg(CSR_TRIG_LEVEL, thr);
         write_reg(CSR_FULL_SCALE, upper);
         write_reg(CSR_CURVE_SELECT, {10'($urandom_range(1023)), curve});
         write_reg(CSR_WINDOW_MS, {4'($urandom_range(15)), window});

         start = n_sent;
         quota = (phase == 1) ? 30 : 95;
         if (phase == 3) begin
            send_sample(hit_level(), 1'b0);
            repeat (260) send_sample(hit_level(), 1'b1);
            send_sample(quiet_level(), 1'b0);
         end
         while (n_sent - start < quota) begin
            if (thr_reg == 12'hFFF || $urandom_range(6) == 0) begin
               repeat ($urandom_range(4, 1))
                  send_sample(12'($urandom_range(4095)), 1'($urandom_range(1)));
            end else begin
               play_stroke();
            end
         end
      end

      settle();
      $display("Sent %0d samples, checked %0d responses, %0d closed windows with velocity;",
               n_sent, n_results, n_closed);
      $display("%0d register writes across %0d directed and random settings, all curves.",
               n_writes, NUM_SETTINGS);
      if (n_errors == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dpvd_pkg.sv
rtl/core/dpvd_track.sv
rtl/core/dpvd_div.sv
rtl/core/drum_pad_velocity_detector.sv
tb/sv/tb.sv
